@@ design/ptt_pkg.sv @@
package ptt_pkg;

    localparam int unsigned COUNT_W = 7;

    // opcodes
    localparam logic [2:0] OP_SCHEDULE   = 3'd0;
    localparam logic [2:0] OP_CANCEL_CHK = 3'd1;
    localparam logic [2:0] OP_CANCEL_ANY = 3'd2;
    localparam logic [2:0] OP_TICK       = 3'd3;
    localparam logic [2:0] OP_CONTAINS   = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ARG   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;

    localparam logic [63:0] DUE_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_BIT        = 64'h8000_0000_0000_0000;
    localparam logic [29:0] MAX_DELAY_RESET = 30'd1000000000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [63:0] now;
        logic [29:0]        delay;
        logic [29:0]        interval;
        logic [7:0]         owner;
        logic [63:0]        task_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [63:0]        result_id;
        logic [7:0]         fired_source;
        logic signed [63:0] fired_due_turn;
        logic [29:0]        fired_interval;
        logic [63:0]        fired_sequence;
        logic [6:0]         task_count;
        logic               last;
    } rsp_t;

    // one buffered result, without count and last
    typedef struct packed {
        logic [2:0]         status;
        logic [63:0]        result_id;
        logic [7:0]         fired_source;
        logic signed [63:0] fired_due_turn;
        logic [29:0]        fired_interval;
        logic [63:0]        fired_sequence;
    } res_rec_t;

endpackage

@@ design/periodic_timer_task_table.sv @@
// channel | direction | handshake           | payload
// cmd     | in        | cmd_valid/cmd_stall | cmd (opcode, now, delay, interval, owner, id)
// rsp     | out       | rsp_valid/rsp_stall | rsp (status, fired task, task_count, last)
// cfg     | in        | cfg_write_en        | cfg_write_data (max_delay_turns)
//
// one command at a time; cmd_stall is high from acceptance until the last beat has gone
// schedule, cancel, contains: a table scan of up to TABLE_DEPTH entries, one entry a cycle
// tick: one full-table scan per fired task and one more that finds none unless
// the fire limit is hit, plus, after each periodic task, a pass through the shared
// remainder unit (one dividend bit a cycle) and the table update
// each result beat is read from the result buffer in S_EMIT_RD and shown in S_EMIT_OUT;
// rsp_stall holds the beat; reset empties the table, resets the counters and sets max_delay_turns to its default
module periodic_timer_task_table
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned FIRE_LIMIT  = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic [29:0]     cfg_write_data,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  ptt_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ptt_pkg::rsp_t   rsp
);
    import ptt_pkg::*;

    localparam int unsigned IW    = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int unsigned LIMIT = FIRE_LIMIT < 16 ? FIRE_LIMIT : 16;
    localparam int unsigned BW    = $clog2(LIMIT > 1 ? LIMIT : 2);
    localparam int unsigned PW    = $clog2(LIMIT + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_DIV      = 7'b0000100,
        S_UPD      = 7'b0001000,
        S_EMIT_RD  = 7'b0010000,
        S_EMIT_OUT = 7'b0100000,
        S_SPARE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [29:0]            max_delay_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] done_reg, done_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [63:0]            id_ctr_reg, id_ctr_next;
    logic [63:0]            ord_ctr_reg, ord_ctr_next;
    logic [PW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg, rd_ptr_next;

    logic [2:0]             op_reg, op_next;
    logic signed [63:0]     now_reg, now_next;
    logic [63:0]            due_new_reg, due_new_next;
    logic [29:0]            interval_reg, interval_next;
    logic [7:0]             src_reg, src_next;
    logic [63:0]            tid_reg, tid_next;
    logic [IW-1:0]          idx_reg, idx_next;

    logic                   best_found_reg, best_found_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic signed [63:0]     best_due_reg, best_due_next;
    logic [63:0]            best_ord_reg, best_ord_next;
    logic [63:0]            best_id_reg, best_id_next;
    logic [7:0]             best_src_reg, best_src_next;
    logic [29:0]            best_per_reg, best_per_next;
    logic [63:0]            d_reg, d_next;
    logic [64:0]            t_reg, t_next;

    // task table
    logic [63:0]        ent_id  [TABLE_DEPTH];
    logic signed [63:0] ent_due [TABLE_DEPTH];
    logic [29:0]        ent_per [TABLE_DEPTH];
    logic [7:0]         ent_src [TABLE_DEPTH];
    logic [63:0]        ent_ord [TABLE_DEPTH];

    logic               sched_wr, upd_wr;
    logic signed [63:0] upd_due;

    logic [63:0]        cur_id;
    logic signed [63:0] cur_due;
    logic [29:0]        cur_per;
    logic [7:0]         cur_src;
    logic [63:0]        cur_ord;

    logic               cand, take, match;
    logic               nb_found;
    logic [IW-1:0]      nb_idx;
    logic signed [63:0] nb_due;
    logic [63:0]        nb_ord, nb_id;
    logic [7:0]         nb_src;
    logic [29:0]        nb_per;

    logic               accept;
    logic               bad_arg, full, ovf;
    logic [64:0]        sched_sum;
    logic [65:0]        upd_sum;

    logic               buf_we;
    res_rec_t           buf_wdata, buf_rdata;

    logic               div_start, div_done;
    logic [29:0]        div_rem;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);

    assign cur_id  = ent_id[idx_reg];
    assign cur_due = ent_due[idx_reg];
    assign cur_per = ent_per[idx_reg];
    assign cur_src = ent_src[idx_reg];
    assign cur_ord = ent_ord[idx_reg];

    assign bad_arg   = (cmd.delay == 30'd0) || (cmd.delay > max_delay_reg)
                       || (cmd.interval > max_delay_reg);
    assign full      = (count_reg == COUNT_W'(TABLE_DEPTH));
    // biased now plus delay carries out exactly when the due turn overflows
    assign sched_sum = {1'b0, cmd.now ^ SIGN_BIT} + {35'd0, cmd.delay};
    assign ovf       = sched_sum[64];

    // running best due task for tick
    always_comb
    begin
        cand = valid_reg[idx_reg] && !done_reg[idx_reg] && (cur_due <= now_reg);
        take = cand && (!best_found_reg || (cur_due < best_due_reg)
               || ((cur_due == best_due_reg) && (cur_ord < best_ord_reg)));
        nb_found = best_found_reg || take;
        nb_idx   = take ? idx_reg : best_idx_reg;
        nb_due   = take ? cur_due : best_due_reg;
        nb_ord   = take ? cur_ord : best_ord_reg;
        nb_id    = take ? cur_id  : best_id_reg;
        nb_src   = take ? cur_src : best_src_reg;
        nb_per   = take ? cur_per : best_per_reg;
        match    = valid_reg[idx_reg] && (cur_id == tid_reg)
                   && ((op_reg != OP_CANCEL_CHK) || (cur_src == src_reg));
    end

    // skip ahead: due plus (now - due - rem + interval), saturating at the int64 maximum
    assign upd_sum = {{2{best_due_reg[63]}}, best_due_reg} + {1'b0, t_reg};
    assign upd_due = ($signed(upd_sum) > $signed({2'b00, DUE_MAX})) ? DUE_MAX
                     : upd_sum[63:0];

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        done_next       = done_reg;
        count_next      = count_reg;
        id_ctr_next     = id_ctr_reg;
        ord_ctr_next    = ord_ctr_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        due_new_next    = due_new_reg;
        interval_next   = interval_reg;
        src_next        = src_reg;
        tid_next        = tid_reg;
        idx_next        = idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_due_next   = best_due_reg;
        best_ord_next   = best_ord_reg;
        best_id_next    = best_id_reg;
        best_src_next   = best_src_reg;
        best_per_next   = best_per_reg;
        d_next          = d_reg;
        t_next          = t_reg;
        sched_wr        = 1'b0;
        upd_wr          = 1'b0;
        buf_we          = 1'b0;
        buf_wdata       = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = cmd.opcode;
                    now_next        = cmd.now;
                    due_new_next    = sched_sum[63:0] ^ SIGN_BIT;
                    interval_next   = cmd.interval;
                    src_next        = cmd.owner;
                    tid_next        = cmd.task_id;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    done_next       = '0;
                    unique case (cmd.opcode) inside
                        OP_SCHEDULE:
                        begin
                            if (bad_arg || full || ovf)
                            begin
                                buf_we           = 1'b1;
                                buf_wdata.status = bad_arg ? ST_BAD_ARG
                                                   : (full ? ST_FULL : ST_OVERFLOW);
                                state_next       = S_EMIT_RD;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        OP_CANCEL_CHK, OP_CANCEL_ANY, OP_CONTAINS, OP_TICK:
                            state_next = S_SCAN;
                        OP_CLEAR:
                        begin
                            valid_next       = '0;
                            count_next       = '0;
                            id_ctr_next      = 64'd1;
                            ord_ctr_next     = 64'd1;
                            buf_we           = 1'b1;
                            buf_wdata.status = ST_OK;
                            state_next       = S_EMIT_RD;
                        end
                        default:
                        begin
                            buf_we           = 1'b1;
                            buf_wdata.status = ST_BAD_ARG;
                            state_next       = S_EMIT_RD;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (op_reg == OP_SCHEDULE)
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        sched_wr              = 1'b1;
                        valid_next[idx_reg]   = 1'b1;
                        count_next            = count_reg + 1'b1;
                        buf_we                = 1'b1;
                        buf_wdata.status      = ST_OK;
                        buf_wdata.result_id   = id_ctr_reg;
                        id_ctr_next           = id_ctr_reg + 64'd1;
                        ord_ctr_next          = ord_ctr_reg + 64'd1;
                        state_next            = S_EMIT_RD;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else if (op_reg == OP_TICK)
                begin
                    if (idx_reg != IDX_LAST)
                    begin
                        idx_next        = idx_reg + 1'b1;
                        best_found_next = nb_found;
                        best_idx_next   = nb_idx;
                        best_due_next   = nb_due;
                        best_ord_next   = nb_ord;
                        best_id_next    = nb_id;
                        best_src_next   = nb_src;
                        best_per_next   = nb_per;
                    end
                    else if (nb_found)
                    begin
                        buf_we                   = 1'b1;
                        buf_wdata.status         = ST_OK;
                        buf_wdata.result_id      = nb_id;
                        buf_wdata.fired_source   = nb_src;
                        buf_wdata.fired_due_turn = nb_due;
                        buf_wdata.fired_interval = nb_per;
                        buf_wdata.fired_sequence = nb_ord;
                        done_next[nb_idx]        = 1'b1;
                        best_idx_next            = nb_idx;
                        best_due_next            = nb_due;
                        best_per_next            = nb_per;
                        idx_next                 = '0;
                        best_found_next          = 1'b0;
                        if (nb_per == 30'd0)
                        begin
                            valid_next[nb_idx] = 1'b0;
                            count_next         = count_reg - 1'b1;
                            if (wr_ptr_reg + 1'b1 == PW'(LIMIT))
                                state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            d_next     = now_reg - nb_due;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        if (wr_ptr_reg == '0)
                        begin
                            buf_we           = 1'b1;
                            buf_wdata.status = ST_NONE_DUE;
                        end
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    // cancel or contains: lowest matching slot wins
                    if (match)
                    begin
                        if (op_reg != OP_CONTAINS)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            count_next          = count_reg - 1'b1;
                        end
                        buf_we           = 1'b1;
                        buf_wdata.status = ST_OK;
                        state_next       = S_EMIT_RD;
                    end
                    else if (idx_reg == IDX_LAST)
                    begin
                        buf_we           = 1'b1;
                        buf_wdata.status = ST_NOT_FOUND;
                        state_next       = S_EMIT_RD;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    t_next     = {1'b0, d_reg} - {35'd0, div_rem} + {35'd0, best_per_reg};
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                upd_wr       = 1'b1;
                ord_ctr_next = ord_ctr_reg + 64'd1;
                if (wr_ptr_reg == PW'(LIMIT))
                    state_next = S_EMIT_RD;
                else
                    state_next = S_SCAN;
            end

            S_EMIT_RD:
                state_next = S_EMIT_OUT;

            S_EMIT_OUT:
            begin
                if (!rsp_stall)
                begin
                    if (rd_ptr_reg + 1'b1 == wr_ptr_reg)
                    begin
                        rd_ptr_next = '0;
                        wr_ptr_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                        state_next  = S_EMIT_RD;
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        if (buf_we)
            wr_ptr_next = wr_ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_delay_reg  <= MAX_DELAY_RESET;
            valid_reg      <= '0;
            done_reg       <= '0;
            count_reg      <= '0;
            id_ctr_reg     <= 64'd1;
            ord_ctr_reg    <= 64'd1;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            op_reg         <= OP_CLEAR;
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_write_en)
                max_delay_reg <= cfg_write_data;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
            id_ctr_reg     <= id_ctr_next;
            ord_ctr_reg    <= ord_ctr_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        due_new_reg  <= due_new_next;
        interval_reg <= interval_next;
        src_reg      <= src_next;
        tid_reg      <= tid_next;
        best_idx_reg <= best_idx_next;
        best_due_reg <= best_due_next;
        best_ord_reg <= best_ord_next;
        best_id_reg  <= best_id_next;
        best_src_reg <= best_src_next;
        best_per_reg <= best_per_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        if (sched_wr)
        begin
            ent_id[idx_reg]  <= id_ctr_reg;
            ent_due[idx_reg] <= due_new_reg;
            ent_per[idx_reg] <= interval_reg;
            ent_src[idx_reg] <= src_reg;
            ent_ord[idx_reg] <= ord_ctr_reg;
        end
        if (upd_wr)
        begin
            ent_due[best_idx_reg] <= upd_due;
            ent_ord[best_idx_reg] <= ord_ctr_reg;
        end
    end

    ptt_rem_unit u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (d_next),
        .divisor   (best_per_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    ptt_res_buf #(.DEPTH(LIMIT)) u_buf
    (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (wr_ptr_reg[BW-1:0]),
        .wr_data (buf_wdata),
        .rd_addr (rd_ptr_reg[BW-1:0]),
        .rd_data (buf_rdata)
    );

    assign rsp_valid           = (state_reg == S_EMIT_OUT);
    assign rsp.status          = buf_rdata.status;
    assign rsp.result_id       = buf_rdata.result_id;
    assign rsp.fired_source    = buf_rdata.fired_source;
    assign rsp.fired_due_turn  = buf_rdata.fired_due_turn;
    assign rsp.fired_interval  = buf_rdata.fired_interval;
    assign rsp.fired_sequence  = buf_rdata.fired_sequence;
    assign rsp.task_count      = count_reg;
    assign rsp.last            = (rd_ptr_reg + 1'b1 == wr_ptr_reg);

    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("task count out of step with valid bits");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd_stall)
        else $error("command taken while busy");

    a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg <= PW'(LIMIT))
        else $error("result buffer overrun");

    a_beat_buffered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (wr_ptr_reg != '0) && (rd_ptr_reg < wr_ptr_reg))
        else $error("beat shown with nothing buffered");

endmodule

@@ design/ptt_rem_unit.sv @@
module ptt_rem_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [29:0] divisor,
    output logic        done,
    output logic [29:0] remainder
);
    logic [6:0]  cnt_reg, cnt_next;
    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [29:0] dvs_reg, dvs_next;
    logic [29:0] rem_reg, rem_next;
    logic [30:0] shifted;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        shifted     = {rem_reg, dvd_reg[63]};
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = 7'd64;
            dvd_next    = dividend;
            dvs_next    = divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
                rem_next = 30'(shifted - {1'b0, dvs_reg});
            else
                rem_next = shifted[29:0];
            dvd_next = {dvd_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/ptt_res_buf.sv @@
module ptt_res_buf
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = $clog2(DEPTH > 1 ? DEPTH : 2)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  ptt_pkg::res_rec_t wr_data,
    input  logic [AW-1:0]     rd_addr,
    output ptt_pkg::res_rec_t rd_data
);
    import ptt_pkg::*;

    res_rec_t mem [DEPTH];
    res_rec_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule
